// ===== rtl/core/bdd_pkg.sv =====
// Package for the batched degrees-to-DMS converter.
// Shared batch token type, fixed-point constants and hemisphere codes.
// No dependencies.
package bdd_pkg;

  localparam int unsigned FracBits   = 23;
  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DegWidth   = 9;
  localparam int unsigned MinWidth   = 7;
  localparam int unsigned SecWidth   = 7;
  localparam int unsigned HemiWidth  = 2;
  localparam int unsigned OutWidth   = 32;

  localparam logic [HemiWidth-1:0] HEMI_N = 2'd0;
  localparam logic [HemiWidth-1:0] HEMI_S = 2'd1;
  localparam logic [HemiWidth-1:0] HEMI_E = 2'd2;
  localparam logic [HemiWidth-1:0] HEMI_W = 2'd3;

  // Batch handed from front to back: which buffer bank is full.
  typedef struct packed {
    logic bank;
  } bdd_batch_t;

endpackage

// ===== rtl/core/bdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bdd_front.sv =====
// Front end: APB register, input stream acceptance and bank fill.
// Writes samples into the buffer RAM and posts a token per full batch.
// Depends on bdd_pkg.
module bdd_front #(
  parameter int unsigned BATCH_DEPTH = 10,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic                   ram_we_o,
  output logic [IDX_W:0]         ram_waddr_o,
  output logic [31:0]            ram_wdata_o,
  output logic                   push_o,
  output bdd_pkg::bdd_batch_t    push_data_o,
  input  logic                   done_i,
  output logic                   is_latitude_o
);
  import bdd_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(BATCH_DEPTH - 1);

  logic [IDX_W-1:0] fill_idx_q, fill_idx_d;
  logic             bank_q, bank_d;
  logic [1:0]       pend_q, pend_d;
  logic             lat_q, lat_d;
  logic             accept, fill_last;

  // Two banks: at most two batches outstanding (queued or draining).
  assign s_axis_tready = (pend_q != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fill_last     = (fill_idx_q == LastIdx);

  assign ram_we_o    = accept;
  assign ram_waddr_o = {bank_q, fill_idx_q};
  assign ram_wdata_o = s_axis_tdata;

  assign push_o           = accept && fill_last;
  assign push_data_o.bank = bank_q;

  assign pready        = 1'b1;
  assign prdata        = {31'd0, lat_q};
  assign is_latitude_o = lat_q;

  always_comb begin
    fill_idx_d = fill_idx_q;
    bank_d     = bank_q;
    lat_d      = lat_q;
    pend_d     = pend_q + {1'b0, push_o} - {1'b0, done_i};
    if (accept) begin
      if (fill_last) begin
        fill_idx_d = '0;
        bank_d     = ~bank_q;
      end else begin
        fill_idx_d = fill_idx_q + 1'b1;
      end
    end
    if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      lat_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_idx_q <= '0;
      bank_q     <= 1'b0;
      pend_q     <= 2'd0;
      lat_q      <= 1'b1;
    end else begin
      fill_idx_q <= fill_idx_d;
      bank_q     <= bank_d;
      pend_q     <= pend_d;
      lat_q      <= lat_d;
    end
  end

endmodule

// ===== rtl/core/bdd_queue.sv =====
// Two-entry token queue between front and back.
// Depends on bdd_pkg.
module bdd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bdd_pkg::bdd_batch_t push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output bdd_pkg::bdd_batch_t data_o
);
  import bdd_pkg::*;

  bdd_batch_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/core/bdd_back.sv =====
// Back end: drains a full bank in order and converts each sample to DMS.
// Read, magnitude/minutes, seconds/output stages with one common stall.
// Depends on bdd_pkg.
module bdd_back #(
  parameter int unsigned BATCH_DEPTH = 10,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bdd_pkg::bdd_batch_t q_data_i,
  output logic                q_pop_o,
  output logic                done_o,
  input  logic                is_latitude_i,
  output logic                ram_re_o,
  output logic [IDX_W:0]      ram_raddr_o,
  input  logic [31:0]         ram_rdata_i,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,
  output logic                m_axis_tlast
);
  import bdd_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(BATCH_DEPTH - 1);
  localparam logic [28:0]      HalfQ   = 29'(1 << (FracBits - 1));

  logic             active_q;
  logic             bank_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             adv, issue, rd_last;

  logic             v1_q, l1_q;
  logic             v2_q, l2_q, neg2_q;
  logic [8:0]       deg_mag2_q;
  logic [28:0]      m60_2_q;

  logic             out_v_q, out_last_q;
  logic [31:0]      out_data_q;

  // Stage 1 logic
  logic             neg1;
  logic [31:0]      mag1;
  logic [22:0]      fm1;
  logic [28:0]      m60_1;

  // Stage 2 logic
  logic [5:0]       min_mag;
  logic [22:0]      rm;
  logic [28:0]      t60;
  logic [29:0]      t_pos;
  logic [28:0]      t_neg;
  logic [5:0]       sec_mag;
  logic [DegWidth-1:0]  deg_s;
  logic [MinWidth-1:0]  min_s;
  logic [SecWidth-1:0]  sec_s;
  logic [HemiWidth-1:0] hemi;
  logic             nonneg;

  assign adv     = !out_v_q || m_axis_tready;
  assign issue   = adv && active_q;
  assign rd_last = (rd_idx_q == LastIdx);
  assign q_pop_o = !active_q && q_valid_i;
  assign done_o  = issue && rd_last;

  assign ram_re_o    = issue;
  assign ram_raddr_o = {bank_q, rd_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      bank_q   <= 1'b0;
      rd_idx_q <= '0;
    end else if (q_pop_o) begin
      active_q <= 1'b1;
      bank_q   <= q_data_i.bank;
      rd_idx_q <= '0;
    end else if (issue) begin
      if (rd_last) begin
        active_q <= 1'b0;
      end
      rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  // Magnitude split: whole degrees and fraction times 60.
  always_comb begin
    neg1  = ram_rdata_i[31];
    mag1  = neg1 ? (32'd0 - ram_rdata_i) : ram_rdata_i;
    fm1   = mag1[22:0];
    m60_1 = {fm1, 6'd0} - {4'd0, fm1, 2'd0};
  end

  // Minutes, rounded seconds, signs and hemisphere.
  always_comb begin
    min_mag = m60_2_q[28:23];
    rm      = m60_2_q[22:0];
    t60     = {rm, 6'd0} - {4'd0, rm, 2'd0};
    t_pos   = {1'b0, t60} + {1'b0, HalfQ};
    t_neg   = t60 - HalfQ;
    if (!neg2_q) begin
      sec_mag = t_pos[28:23];
    end else if (t60 >= HalfQ) begin
      sec_mag = t_neg[28:23];
    end else begin
      sec_mag = 6'd0;
    end
    deg_s  = neg2_q ? (9'd0 - deg_mag2_q) : deg_mag2_q;
    min_s  = neg2_q ? (7'd0 - {1'b0, min_mag}) : {1'b0, min_mag};
    sec_s  = neg2_q ? (7'd0 - {1'b0, sec_mag}) : {1'b0, sec_mag};
    nonneg = !(neg2_q && (deg_mag2_q != 9'd0));
    if (nonneg) begin
      hemi = is_latitude_i ? HEMI_N : HEMI_E;
    end else begin
      hemi = is_latitude_i ? HEMI_S : HEMI_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= issue;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q       <= rd_last;
      l2_q       <= l1_q;
      neg2_q     <= neg1;
      deg_mag2_q <= mag1[31:23];
      m60_2_q    <= m60_1;
      out_last_q <= l2_q;
      out_data_q <= {7'd0, hemi, sec_s, min_s, deg_s};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/batched_degrees_to_dms_top.sv =====
// Order: a completed batch is queued, then read and converted in the back end's stages;
// its results then leave one result per cycle while m_axis_tready is high.
// Throughput: one input per cycle; a two-bank buffer lets the next batch fill
// while the previous one drains, input stalls only with two batches pending.
// Reset: asynchronous, active low; clears counters, queue and valids,
// is_latitude returns to 1. Partial batches are held, never emitted.
module batched_degrees_to_dms_top #(
  parameter int unsigned BATCH_DEPTH = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] coordinate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [8:0] whole_degrees, [15:9] whole_minutes,
                                      // [22:16] rounded_seconds, [24:23] hemisphere
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdd_pkg::*;

  localparam int unsigned IdxW    = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int unsigned RamDepth = 2 << IdxW;

  logic            ram_we, ram_re;
  logic [IdxW:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;
  logic            push, pop, q_valid, done, is_lat;
  bdd_batch_t      push_data, q_data;

  bdd_front #(.BATCH_DEPTH(BATCH_DEPTH), .IDX_W(IdxW)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .ram_we_o(ram_we), .ram_waddr_o(ram_waddr), .ram_wdata_o(ram_wdata),
    .push_o(push), .push_data_o(push_data),
    .done_i(done), .is_latitude_o(is_lat)
  );

  bdd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_data)
  );

  bdd_ram #(.WIDTH(CoordWidth), .DEPTH(RamDepth)) u_ram (
    .clk_i,
    .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  bdd_back #(.BATCH_DEPTH(BATCH_DEPTH), .IDX_W(IdxW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(pop),
    .done_o(done), .is_latitude_i(is_lat),
    .ram_re_o(ram_re), .ram_raddr_o(ram_raddr), .ram_rdata_i(ram_rdata),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule

// ===== rtl/core/bdd_checker.sv =====
// Port-level checker for batched_degrees_to_dms_top, bound to the top level.
// Depends on the top level's port list and its BATCH_DEPTH parameter only.
module bdd_checker #(
  parameter int unsigned BATCH_DEPTH = 10
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  localparam int unsigned CntW = $clog2(BATCH_DEPTH + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(BATCH_DEPTH - 1);

  logic [CntW-1:0] out_cnt_q;
  logic            out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
    end else if (out_acc) begin
      out_cnt_q <= (out_cnt_q == LastCnt) ? '0 : out_cnt_q + 1'b1;
    end
  end

  a_last_per_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast == (out_cnt_q == LastCnt)))
    else $error("tlast not on final result of batch");

  a_hemi_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23] == m_axis_tdata[8]))
    else $error("hemisphere disagrees with sign of degrees");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

endmodule

bind batched_degrees_to_dms_top bdd_checker #(.BATCH_DEPTH(BATCH_DEPTH)) u_bdd_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);

// ===== sim/batched_degrees_to_dms_top_test.sv =====
// Testbench for batched_degrees_to_dms_top: streams Q9.23 coordinates, predicts the
// degrees/minutes/seconds of each drained batch and checks every output transaction.
// Depends on bdd_pkg and the top-level RTL.
module batched_degrees_to_dms_top_test;
  import bdd_pkg::*;

  localparam int unsigned BatchDepth   = 10;
  localparam logic [2:0]  RegIsLatitude = 3'd0;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PhaseItems   = 85;
  localparam int unsigned DirectedRows = 20;
  localparam longint      OneQ         = longint'(1) << FracBits;
  localparam longint      HalfQ        = longint'(1) << (FracBits - 1);

  typedef struct packed {
    logic signed [DegWidth-1:0] degs;
    logic signed [MinWidth-1:0] mins;
    logic signed [SecWidth-1:0] secs;
    logic [HemiWidth-1:0]       hemi;
    logic                       last;
  } dms_t;

  typedef struct packed {
    logic [CoordWidth-1:0]      coord;
    logic                       known;
    logic signed [DegWidth-1:0] degs;
    logic signed [MinWidth-1:0] mins;
    logic signed [SecWidth-1:0] secs;
    logic [HemiWidth-1:0]       hemi;
  } dms_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dms_t        dms_due[$];
  dms_row_t    held_rows[$];
  logic        lat_shadow = 1'b1;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // rows with known = 1 carry the result as typed in; the rest go through dms_of
  dms_row_t directed_rows [DirectedRows] = '{
    '{32'h0000_0000, 1'b1,    0, 0, 0, HEMI_N},
    '{32'h5A00_0000, 1'b1,  180, 0, 0, HEMI_N},
    '{32'hA600_0000, 1'b1, -180, 0, 0, HEMI_S},
    '{32'h7FFF_FFFF, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h8000_0000, 1'b1, -256, 0, 0, HEMI_S},
    '{32'h0080_0000, 1'b1,    1, 0, 0, HEMI_N},
    '{32'hFF80_0000, 1'b1,   -1, 0, 0, HEMI_S},
    '{32'hFFFF_FFFF, 1'b1,    0, 0, 0, HEMI_N},
    '{32'h0002_2222, 1'b0,    0, 0, 0, HEMI_N},
    '{32'hFFFD_DDDE, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h0000_0000, 1'b1,    0, 0, 0, HEMI_E},
    '{32'hFFC0_0000, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h16C0_0000, 1'b0,    0, 0, 0, HEMI_N},
    '{32'hFF80_0001, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h5A00_0000, 1'b1,  180, 0, 0, HEMI_E},
    '{32'hA600_0000, 1'b1, -180, 0, 0, HEMI_W},
    '{32'h0002_2221, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h7FFF_FFFF, 1'b0,    0, 0, 0, HEMI_N},
    '{32'h8000_0000, 1'b1, -256, 0, 0, HEMI_W},
    '{32'h5555_5555, 1'b0,    0, 0, 0, HEMI_N}
  };

  batched_degrees_to_dms_top #(
    .BATCH_DEPTH(BatchDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic dms_t dms_of(input logic [CoordWidth-1:0] raw, input logic lat);
    longint x, deg, frac, m60, mins, rem, secs;
    dms_t   d;
    x    = longint'($signed(raw));
    deg  = x / OneQ;
    frac = x - deg * OneQ;
    m60  = frac * 60;
    mins = m60 / OneQ;
    rem  = m60 - mins * OneQ;
    secs = (rem * 60 + HalfQ) / OneQ;
    d.degs = deg[DegWidth-1:0];
    d.mins = mins[MinWidth-1:0];
    d.secs = secs[SecWidth-1:0];
    if (deg > -1) begin
      d.hemi = lat ? HEMI_N : HEMI_E;
    end else begin
      d.hemi = lat ? HEMI_S : HEMI_W;
    end
    d.last = 1'b0;
    return d;
  endfunction

  function automatic logic [31:0] random_coord();
    int          k;
    int          m;
    int          x;
    logic [31:0] u;
    case ($urandom_range(0, 9))
      0: begin
        return $urandom();
      end
      1: begin
        k = $urandom_range(0, 360);
        k -= 180;
        return 32'(k * 8388608);
      end
      2: begin
        k = $urandom_range(0, 8388607);
        return $urandom_range(0, 1) ? 32'(-k) : 32'(k);
      end
      3: begin
        // close to a minute boundary, where seconds round up to 60
        k = $urandom_range(0, 179);
        m = $urandom_range(0, 59);
        x = k * 8388608 + m * 139810 + $urandom_range(0, 6) - 3;
        return $urandom_range(0, 1) ? 32'(-x) : 32'(x);
      end
      default: begin
        u = $urandom_range(0, 32'd3019898880);
        return u - 32'd1509949440;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  // expected results are worked out when the batch fills, with the register as it stands then
  task automatic note_accept(input dms_row_t row);
    dms_t d;
    held_rows.push_back(row);
    if (held_rows.size() == BatchDepth) begin
      for (int i = 0; i < BatchDepth; i++) begin
        if (held_rows[i].known) begin
          d.degs = held_rows[i].degs;
          d.mins = held_rows[i].mins;
          d.secs = held_rows[i].secs;
          d.hemi = held_rows[i].hemi;
        end else begin
          d = dms_of(held_rows[i].coord, lat_shadow);
        end
        d.last = (i == BatchDepth - 1);
        dms_due.push_back(d);
      end
      held_rows.delete();
    end
  endtask

  task automatic push_coord(input dms_row_t row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.coord;
    do @(posedge clk_i); while (!s_axis_tready);
    note_accept(row);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (dms_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_latitude_reg(input logic want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RegIsLatitude;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== want) flag_mismatch("is_latitude readback", prdata[0], want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_latitude(input logic lat);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegIsLatitude;
    pwdata  <= {31'b0, lat};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    lat_shadow = lat;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    check_latitude_reg(lat);
  endtask

  task automatic check_result();
    dms_t want;
    if (dms_due.size() == 0) begin
      flag_mismatch("transaction with nothing expected", m_axis_tdata, 0);
      return;
    end
    want = dms_due.pop_front();
    if (m_axis_tdata[8:0] !== want.degs)
      flag_mismatch("whole_degrees", $signed(m_axis_tdata[8:0]), want.degs);
    if (m_axis_tdata[15:9] !== want.mins)
      flag_mismatch("whole_minutes", $signed(m_axis_tdata[15:9]), want.mins);
    if (m_axis_tdata[22:16] !== want.secs)
      flag_mismatch("rounded_seconds", $signed(m_axis_tdata[22:16]), want.secs);
    if (m_axis_tdata[24:23] !== want.hemi)
      flag_mismatch("hemisphere", m_axis_tdata[24:23], want.hemi);
    if (m_axis_tlast !== want.last)
      flag_mismatch("last_of_batch", m_axis_tlast, want.last);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      if (hold_req) begin
        stall_left = LongHold;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    dms_row_t row;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_latitude_reg(1'b1);

    for (int i = 0; i < DirectedRows; i++) begin
      if (i == BatchDepth) begin
        wait_drained();
        set_latitude(1'b0);
      end
      push_coord(directed_rows[i]);
    end

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      if (phase == 3) idle_on = 1'b0;
      set_latitude(phase == 3 ? 1'($urandom_range(0, 1)) : ~phase[0]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 5) hold_req = 1'b1;
        row       = '0;
        row.coord = random_coord();
        push_coord(row);
      end
    end
    wait_drained();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bdd_pkg.sv
rtl/core/bdd_ram.sv
rtl/core/bdd_front.sv
rtl/core/bdd_queue.sv
rtl/core/bdd_back.sv
rtl/core/batched_degrees_to_dms_top.sv
rtl/core/bdd_checker.sv
sim/batched_degrees_to_dms_top_test.sv
